FILE: src/fec_gold_code_symbol_spreader_defines.svh
// assertion macros for the symbol spreader
`ifndef FEC_GOLD_CODE_SYMBOL_SPREADER_DEFINES_SVH
`define FEC_GOLD_CODE_SYMBOL_SPREADER_DEFINES_SVH

`ifndef SYNTH
// property checked at every rising edge outside reset
`define FGCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition that must bring a property in the same cycle
`define FGCS_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
`else
`define FGCS_ASSERT(label, prop, msg)
`define FGCS_ASSERT_IMPL(label, cond, prop, msg)
`endif

`endif

FILE: src/fgcs_pkg.sv
package fgcs_pkg;

  localparam int unsigned FRAME_LEN  = 30;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned CODE_WORDS = 8;

  typedef logic [FRAME_LEN-1:0] frame_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [63:0]          code_word_t;

  localparam pos_t LAST_POS = pos_t'(FRAME_LEN - 1);

  // frame framing symbols, first sent in the top bit
  localparam logic [6:0] PREAMBLE  = 7'b1110010;
  localparam logic [6:0] POSTAMBLE = 7'b1011000;

  // 512-chip spreading codes, word 0 first, lowest code byte in the top bits
  localparam code_word_t CODE_ZERO [CODE_WORDS] = '{
    64'h015ED4610BF3315C, 64'h66925B2AE0A300E1,
    64'hBB9F31CFF7C0B275, 64'hAAA7A5120F5B023D,
    64'h4E608E1734856145, 64'h06A2362FA91FD7FD,
    64'h9D481918AF369300, 64'h1085281D5CAF64DA
  };

  localparam code_word_t CODE_ONE [CODE_WORDS] = '{
    64'hFD3E77D525EF2C69, 64'h2AE93CC40793C507,
    64'h371F7BD1BA079037, 64'hDF5AEDC88C699729,
    64'hACD9D61AD6A805D3, 64'h6ACBD6523FE78286,
    64'h6E9A65A62E54F47A, 64'hCB2E63BF54C4D454
  };

endpackage

FILE: src/fgcs_in_if.sv
interface fgcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

FILE: src/fgcs_out_if.sv
interface fgcs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] chips_0;
  logic [63:0] chips_1;
  logic [63:0] chips_2;
  logic [63:0] chips_3;
  logic [63:0] chips_4;
  logic [63:0] chips_5;
  logic [63:0] chips_6;
  logic [63:0] chips_7;
  logic        symbol_bit;
  logic [4:0]  symbol_position;
  logic        last_symbol;

  modport source (
    output valid, input ready,
    output chips_0, output chips_1, output chips_2, output chips_3,
    output chips_4, output chips_5, output chips_6, output chips_7,
    output symbol_bit, output symbol_position, output last_symbol
  );
  modport sink (
    input valid, output ready,
    input chips_0, input chips_1, input chips_2, input chips_3,
    input chips_4, input chips_5, input chips_6, input chips_7,
    input symbol_bit, input symbol_position, input last_symbol
  );
endinterface

FILE: src/fec_gold_code_symbol_spreader.sv
// symbol spreader with (16,8,5) block-code protection
//
// data channel (sink): one payload byte per request. symbols channel (source):
// thirty results per byte, one per frame symbol, in the order preamble 1110010,
// parity bits msb first, data bits msb first, postamble 1011000. each result
// carries the 512-chip code word for its symbol in chips_0..chips_7, the
// symbol value, its position 0..29 and a flag on position 29.
//
// the first symbol of a byte moves from the frame register into the output
// register at the first advance after the byte is taken. throughput: one symbol
// per cycle while the receiver does not stall, set by the 30-bit frame shift
// register that feeds the output register one symbol a cycle. the next byte is
// taken in the cycle the last symbol of the current frame moves into the output
// register, so frames follow each other with no gap.
//
// reset clears the busy flag, the symbol counter and the output valid; no
// result is pending afterwards. when the receiver stalls, the output register
// holds its result and the frame register stops shifting; data ready stays
// low until the last symbol of the frame can move to the output.
`include "fec_gold_code_symbol_spreader_defines.svh"

module fec_gold_code_symbol_spreader
  import fgcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  fgcs_in_if.sink           data,
  fgcs_out_if.source        symbols
);

  frame_t frame_enc;
  frame_t frame;
  logic   busy;
  pos_t   pos;

  logic   out_valid;
  logic   out_bit;
  pos_t   out_pos;
  logic   out_last;

  logic   advance;
  logic   last_adv;
  logic   take;

  // parity and frame assembly for the incoming byte
  fgcs_frame_enc u_frame_enc (
    .data_byte (data.data_byte),
    .frame     (frame_enc)
  );

  // a symbol moves to the output when the output register is free or drains
  assign advance  = busy && (!out_valid || symbols.ready);
  assign last_adv = advance && (pos == LAST_POS);

  // a new byte is taken when idle or while the last symbol leaves
  assign data.ready = !busy || last_adv;
  assign take       = data.valid && data.ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b1;
        pos  <= '0;
      end else if (last_adv) begin
        busy <= 1'b0;
        pos  <= '0;
      end else if (advance) begin
        pos <= pos + pos_t'(1);
      end

      if (advance) begin
        out_valid <= 1'b1;
      end else if (symbols.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frame shift register and output payload
  always_ff @(posedge clk) begin
    if (take) begin
      frame <= frame_enc;
    end else if (advance) begin
      frame <= {frame[FRAME_LEN-2:0], 1'b0};
    end

    if (advance) begin
      out_bit  <= frame[FRAME_LEN-1];
      out_pos  <= pos;
      out_last <= (pos == LAST_POS);
    end
  end

  // code word select from the registered symbol
  assign symbols.valid           = out_valid;
  assign symbols.chips_0         = out_bit ? CODE_ONE[0] : CODE_ZERO[0];
  assign symbols.chips_1         = out_bit ? CODE_ONE[1] : CODE_ZERO[1];
  assign symbols.chips_2         = out_bit ? CODE_ONE[2] : CODE_ZERO[2];
  assign symbols.chips_3         = out_bit ? CODE_ONE[3] : CODE_ZERO[3];
  assign symbols.chips_4         = out_bit ? CODE_ONE[4] : CODE_ZERO[4];
  assign symbols.chips_5         = out_bit ? CODE_ONE[5] : CODE_ZERO[5];
  assign symbols.chips_6         = out_bit ? CODE_ONE[6] : CODE_ZERO[6];
  assign symbols.chips_7         = out_bit ? CODE_ONE[7] : CODE_ZERO[7];
  assign symbols.symbol_bit      = out_bit;
  assign symbols.symbol_position = out_pos;
  assign symbols.last_symbol     = out_last;

  // symbol counter never runs past the frame
  `FGCS_ASSERT(a_pos_range, pos <= LAST_POS, "symbol counter out of range")

  // a byte is only taken when no frame is pending beyond its last symbol
  `FGCS_ASSERT(a_take_ok, take |-> (!busy || (advance && pos == LAST_POS)),
               "byte taken mid frame")

  // counter steps by one on each symbol inside a frame
  `FGCS_ASSERT(a_pos_step, (advance && pos != LAST_POS && !take) |=>
               (busy && pos == $past(pos) + pos_t'(1)), "symbol counter skipped")

  // a stalled result keeps its position
  `FGCS_ASSERT(a_out_hold, (out_valid && !symbols.ready) |=>
               (out_valid && $stable(out_pos) && $stable(out_bit)),
               "stalled result changed")

  // the end-of-frame flag only sits on the last position
  `FGCS_ASSERT_IMPL(a_last_pos, out_valid && out_last, out_pos == LAST_POS,
                    "last flag on wrong position")

endmodule

FILE: src/fgcs_frame_enc.sv
module fgcs_frame_enc
  import fgcs_pkg::*;
(
  input  logic [7:0] data_byte,
  output frame_t     frame
);

  logic [7:0] d;
  logic [7:0] p;

  assign d = data_byte;

  // (16,8,5) block code parity
  assign p[7] = d[7] ^ d[5] ^ d[2] ^ d[0];
  assign p[6] = d[6] ^ d[5] ^ d[4] ^ d[2] ^ d[1] ^ d[0];
  assign p[5] = d[4] ^ d[3] ^ d[2] ^ d[1];
  assign p[4] = d[7] ^ d[3] ^ d[2] ^ d[1] ^ d[0];
  assign p[3] = d[7] ^ d[6] ^ d[5] ^ d[1];
  assign p[2] = d[7] ^ d[6] ^ d[5] ^ d[4] ^ d[0];
  assign p[1] = d[7] ^ d[6] ^ d[4] ^ d[3] ^ d[2] ^ d[0];
  assign p[0] = d[5] ^ d[4] ^ d[3] ^ d[0];

  assign frame = {PREAMBLE, p, d, POSTAMBLE};

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

// 512-chip spreading codes, word 0 in the top 64 bits, kept apart from the rtl tables
localparam logic [511:0] ZERO_CHIPS = {
  64'h015ED4610BF3315C, 64'h66925B2AE0A300E1,
  64'hBB9F31CFF7C0B275, 64'hAAA7A5120F5B023D,
  64'h4E608E1734856145, 64'h06A2362FA91FD7FD,
  64'h9D481918AF369300, 64'h1085281D5CAF64DA
};
localparam logic [511:0] ONE_CHIPS = {
  64'hFD3E77D525EF2C69, 64'h2AE93CC40793C507,
  64'h371F7BD1BA079037, 64'hDF5AEDC88C699729,
  64'hACD9D61AD6A805D3, 64'h6ACBD6523FE78286,
  64'h6E9A65A62E54F47A, 64'hCB2E63BF54C4D454
};

// frame framing, first symbol in the top bit
localparam logic [6:0] SYNC_HEAD   = 7'b1110010;
localparam logic [6:0] SYNC_TAIL   = 7'b1011000;
localparam int         FRAME_SYMS  = 30;

typedef struct packed {
  logic [511:0] chips;
  logic         sym;
  logic [4:0]   pos;
  logic         last;
} spread_symbol_t;

class spread_scoreboard;
  spread_symbol_t symbol_q[$];
  int unsigned    mismatches;
  int unsigned    bytes_taken;
  int unsigned    symbols_checked;

  function new();
    mismatches      = 0;
    bytes_taken     = 0;
    symbols_checked = 0;
  endfunction

  // (16,8,5) parity word of one payload byte
  function logic [7:0] parity_of(logic [7:0] d);
    logic [7:0] p;
    p[7] = d[7] ^ d[5] ^ d[2] ^ d[0];
    p[6] = d[6] ^ d[5] ^ d[4] ^ d[2] ^ d[1] ^ d[0];
    p[5] = d[4] ^ d[3] ^ d[2] ^ d[1];
    p[4] = d[7] ^ d[3] ^ d[2] ^ d[1] ^ d[0];
    p[3] = d[7] ^ d[6] ^ d[5] ^ d[1];
    p[2] = d[7] ^ d[6] ^ d[5] ^ d[4] ^ d[0];
    p[1] = d[7] ^ d[6] ^ d[4] ^ d[3] ^ d[2] ^ d[0];
    p[0] = d[5] ^ d[4] ^ d[3] ^ d[0];
    return p;
  endfunction

  function void note_byte(logic [7:0] d);
    logic [29:0]    frame;
    spread_symbol_t s;
    frame = {SYNC_HEAD, parity_of(d), d, SYNC_TAIL};
    for (int k = 0; k < FRAME_SYMS; k++) begin
      s.sym   = frame[FRAME_SYMS-1-k];
      s.chips = s.sym ? ONE_CHIPS : ZERO_CHIPS;
      s.pos   = 5'(k);
      s.last  = (k == FRAME_SYMS - 1);
      symbol_q.push_back(s);
    end
    bytes_taken++;
  endfunction

  function int pending();
    return symbol_q.size();
  endfunction

  task report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task check_symbol(spread_symbol_t got);
    spread_symbol_t want;
    logic [63:0]    gw;
    logic [63:0]    ww;
    if (symbol_q.size() == 0) begin
      report_mismatch($sformatf("symbol at position %0d with no frame pending", got.pos));
      return;
    end
    want = symbol_q.pop_front();
    symbols_checked++;
    for (int k = 0; k < 8; k++) begin
      gw = got.chips[511-64*k -: 64];
      ww = want.chips[511-64*k -: 64];
      if (gw !== ww)
        report_mismatch($sformatf("pos %0d chips_%0d got %h want %h", want.pos, k, gw, ww));
    end
    if (got.sym !== want.sym)
      report_mismatch($sformatf("pos %0d symbol_bit got %b want %b", want.pos, got.sym,
                                want.sym));
    if (got.pos !== want.pos)
      report_mismatch($sformatf("symbol_position got %0d want %0d", got.pos, want.pos));
    if (got.last !== want.last)
      report_mismatch($sformatf("pos %0d last_symbol got %b want %b", want.pos, got.last,
                                want.last));
  endtask
endclass

module tb;

  // generous bound: every symbol waiting out the longest stall, several times over
  localparam int unsigned CYCLE_LIMIT = 1_200_000;
  localparam int unsigned RAND_BYTES  = 460;
  // the final stretch of the random part runs with no idling at all
  localparam int unsigned QUIET_TAIL  = 100;

  logic clk;
  logic rst;
  bit   idle_on;
  int unsigned cycles = 0;

  spread_scoreboard board;

  fgcs_in_if  data_ch();
  fgcs_out_if symbol_ch();

  fec_gold_code_symbol_spreader dut (
    .clk     (clk),
    .rst     (rst),
    .data    (data_ch),
    .symbols (symbol_ch)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog, counts every edge from time zero
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d symbols still pending", cycles, board.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // input monitor: a byte request taken at this edge expands to its full frame
  always @(posedge clk) begin
    if (!rst && data_ch.valid && data_ch.ready)
      board.note_byte(data_ch.data_byte);
  end

  // output monitor: every accepted symbol is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && symbol_ch.valid && symbol_ch.ready)
      board.check_symbol('{chips: {symbol_ch.chips_0, symbol_ch.chips_1, symbol_ch.chips_2,
                                   symbol_ch.chips_3, symbol_ch.chips_4, symbol_ch.chips_5,
                                   symbol_ch.chips_6, symbol_ch.chips_7},
                           sym:   symbol_ch.symbol_bit,
                           pos:   symbol_ch.symbol_position,
                           last:  symbol_ch.last_symbol});
  end

  // receiver: ready held high for random stretches, dropped in random stall bursts while idling is on
  initial begin
    symbol_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        symbol_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        symbol_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // one byte request; valid stays up into the next request when no gap follows
  task send_byte(logic [7:0] d);
    data_ch.valid     <= 1'b1;
    data_ch.data_byte <= d;
    do @(posedge clk); while (!data_ch.ready);
    // sender gap burst, lands on a random phase of the frame in flight
    if (idle_on && $urandom_range(0, 3) == 0) begin
      data_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // hold the sender until every queued symbol has come out
  task wait_drained();
    while (board.pending() != 0) @(posedge clk);
  endtask

  function logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'(1 << $urandom_range(0, 7));
      3:       return ~8'(1 << $urandom_range(0, 7));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  logic [7:0] directed_bytes [20] = '{
    8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h02, 8'h04, 8'h08, 8'h10,
    8'h20, 8'h40, 8'hDA, 8'hFD, 8'h54, 8'h7F, 8'hFE, 8'h0F, 8'hF0, 8'h3C
  };

  initial begin
    board = new();
    idle_on = 1'b1;
    rst    <= 1'b1;
    data_ch.valid     <= 1'b0;
    data_ch.data_byte <= 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: all-zero and all-one bytes, single bits, alternating patterns
    foreach (directed_bytes[i])
      send_byte(directed_bytes[i]);

    // sender pauses until the output side has emptied
    data_ch.valid <= 1'b0;
    wait_drained();
    @(posedge clk);

    // random bytes, idling on both sides, then a quiet tail at full rate
    for (int n = 0; n < RAND_BYTES; n++) begin
      if (n == RAND_BYTES - QUIET_TAIL)
        idle_on = 1'b0;
      send_byte(pick_byte());
    end
    data_ch.valid <= 1'b0;

    wait_drained();
    repeat (60) @(posedge clk);

    $display("spreader run: %0d byte requests framed, %0d symbols compared",
             board.bytes_taken, board.symbols_checked);
    $display("stimulus: extreme and single-bit bytes, random bytes under random stalls");
    if (board.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/fgcs_pkg.sv
src/fgcs_in_if.sv
src/fgcs_out_if.sv
src/fgcs_frame_enc.sv
src/fec_gold_code_symbol_spreader.sv
verif/tb.sv
